[hdl/lmom_pkg.sv]
// lmom_pkg: shared types and codes of the limit/market order matcher
// no dependencies
package lmom_pkg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LRD,
        S_LCHK,
        S_SCHK,
        S_FILL,
        S_RRD,
        S_RCHK,
        S_STAT
    } t_state;

    localparam logic [2:0] K_FILL    = 3'd0;
    localparam logic [2:0] K_RESTED  = 3'd1;
    localparam logic [2:0] K_DONE    = 3'd2;
    localparam logic [2:0] K_DISCARD = 3'd3;
    localparam logic [2:0] K_REJECT  = 3'd4;

    localparam int QTY_W   = 20;
    localparam int ID_W    = 32;
    localparam int PRICE_W = 8;

endpackage

[hdl/limit_market_order_matcher_core.sv]
// limit_market_order_matcher_core: price-time priority book, depends on lmom_pkg
// an accepted order reads (S_LRD) and checks (S_LCHK) each level it visits; a fill
// reads the slot (S_SCHK) and emits a fill item (S_FILL), a rested remainder passes
// S_RRD and S_RCHK, and a closing status item (S_STAT) ends each order; a market order may
// visit every level; throughput: one order at a time, output stalls hold the waiting
// item; reset: a clearing pass zeroes the level memory, stalling orders during it
module limit_market_order_matcher_core
    import lmom_pkg::*;
#(
    parameter int PRICE_LEVELS = 256,
    parameter int LEVEL_DEPTH  = 16,
    parameter int MAX_FILLS    = 63
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_is_buy,
    input  logic               i_is_market,
    input  logic [QTY_W-1:0]   i_order_qty,
    input  logic [PRICE_W-1:0] i_price_tick,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_item_kind,
    output logic [ID_W-1:0]    o_trade_number,
    output logic [ID_W-1:0]    o_buyer_id,
    output logic [ID_W-1:0]    o_seller_id,
    output logic [QTY_W-1:0]   o_fill_qty,
    output logic [PRICE_W-1:0] o_fill_price,
    output logic [QTY_W-1:0]   o_left_qty,
    output logic               o_last_item
);

    localparam int LVL_W = $clog2(PRICE_LEVELS);
    localparam int POS_W = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int NF_W  = $clog2(MAX_FILLS + 1);
    localparam int LA_W  = LVL_W + 1;
    localparam int SA_W  = LA_W + POS_W;
    localparam int LV_DW = POS_W + CNT_W;
    localparam int SL_DW = QTY_W + ID_W;
    localparam logic [LVL_W-1:0] LVL_TOP  = LVL_W'(PRICE_LEVELS - 1);
    localparam logic [POS_W-1:0] POS_TOP  = POS_W'(LEVEL_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LEVEL_DEPTH);
    localparam logic [SUM_W-1:0] SUM_D    = SUM_W'(LEVEL_DEPTH);
    localparam logic [NF_W-1:0]  NF_MAX   = NF_W'(MAX_FILLS);

    // level memory: {side, level} -> {head, count}, side 1 = asks
    logic [LV_DW-1:0] lv_mem [2**LA_W];
    logic [LV_DW-1:0] r_lv_rd;
    logic             lv_we;
    logic [LA_W-1:0]  lv_wa, lv_ra;
    logic [LV_DW-1:0] lv_wd;

    // slot memory: {side, level, position} -> {qty, id}
    logic [SL_DW-1:0] sl_mem [2**SA_W];
    logic [SL_DW-1:0] r_sl_rd;
    logic             sl_we;
    logic [SA_W-1:0]  sl_wa, sl_ra;
    logic [SL_DW-1:0] sl_wd;

    always_ff @(posedge i_clk) begin
        if (lv_we) begin
            lv_mem[lv_wa] <= lv_wd;
        end
        r_lv_rd <= lv_mem[lv_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sl_we) begin
            sl_mem[sl_wa] <= sl_wd;
        end
        r_sl_rd <= sl_mem[sl_ra];
    end

    t_state r_state, n_state;
    logic [LA_W-1:0]    r_clr, n_clr;
    logic               r_buy, n_buy, r_mkt, n_mkt;
    logic [QTY_W-1:0]   r_left, n_left, r_q, n_q, r_rq, n_rq;
    logic [PRICE_W-1:0] r_price, n_price;
    logic [ID_W-1:0]    r_oid, n_oid, r_rid, n_rid;
    logic [ID_W-1:0]    r_next_id, n_next_id, r_trade, n_trade;
    logic [LVL_W-1:0]   r_lvl, n_lvl;
    logic [NF_W-1:0]    r_n, n_n;
    logic [2:0]         r_kind, n_kind;
    logic [POS_W-1:0]   r_head, n_head;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    logic               r_ovalid, n_ovalid;
    logic [2:0]         r_o_kind, n_o_kind;
    logic [ID_W-1:0]    r_o_trade, n_o_trade, r_o_buyer, n_o_buyer, r_o_seller, n_o_seller;
    logic [QTY_W-1:0]   r_o_qty, n_o_qty, r_o_left, n_o_left;
    logic [PRICE_W-1:0] r_o_price, n_o_price;
    logic               r_o_last, n_o_last;

    logic               can_out, accept, price_ok, opp, lvl_end;
    logic [POS_W-1:0]   lv_head, next_head, tail;
    logic [CNT_W-1:0]   lv_cnt;
    logic [SUM_W-1:0]   tail_sum;
    logic [QTY_W-1:0]   sl_qty, min_q, left_after;
    logic [ID_W-1:0]    sl_id;

    assign can_out    = !r_ovalid || !i_stall;
    assign o_stall    = (r_state != S_IDLE);
    assign accept     = i_valid && (r_state == S_IDLE);
    assign price_ok   = int'(i_price_tick) < PRICE_LEVELS;
    assign opp        = r_buy;
    assign lv_head    = r_lv_rd[LV_DW-1:CNT_W];
    assign lv_cnt     = r_lv_rd[CNT_W-1:0];
    assign sl_qty     = r_sl_rd[SL_DW-1:ID_W];
    assign sl_id      = r_sl_rd[ID_W-1:0];
    assign min_q      = (sl_qty < r_left) ? sl_qty : r_left;
    assign next_head  = (r_head == POS_TOP) ? '0 : r_head + 1'b1;
    assign tail_sum   = SUM_W'(lv_head) + SUM_W'(lv_cnt);
    assign tail       = POS_W'((tail_sum >= SUM_D) ? tail_sum - SUM_D : tail_sum);
    assign left_after = r_left - r_q;
    assign lvl_end    = r_buy ? (r_lvl == LVL_TOP) : (r_lvl == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (&r_clr) n_state = S_IDLE;
            S_IDLE: begin
                if (i_valid) begin
                    if (i_order_qty == '0 || (!i_is_market && !price_ok)) begin
                        n_state = S_STAT;
                    end else begin
                        n_state = S_LRD;
                    end
                end
            end
            S_LRD: n_state = S_LCHK;
            S_LCHK: begin
                if (lv_cnt == '0) begin
                    if (!r_mkt) n_state = S_RRD;
                    else if (lvl_end) n_state = S_STAT;
                    else n_state = S_LRD;
                end else if (r_n >= NF_MAX) begin
                    n_state = S_STAT;
                end else begin
                    n_state = S_SCHK;
                end
            end
            S_SCHK: n_state = S_FILL;
            S_FILL: if (can_out) n_state = (left_after == '0) ? S_STAT : S_LRD;
            S_RRD: n_state = S_RCHK;
            S_RCHK: n_state = S_STAT;
            S_STAT: if (can_out) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // datapath and memory ports
    always_comb begin
        n_clr = r_clr; n_buy = r_buy; n_mkt = r_mkt; n_left = r_left; n_q = r_q;
        n_rq = r_rq; n_price = r_price; n_oid = r_oid; n_rid = r_rid;
        n_next_id = r_next_id; n_trade = r_trade; n_lvl = r_lvl; n_n = r_n;
        n_kind = r_kind; n_head = r_head; n_cnt = r_cnt;
        n_ovalid = r_ovalid && i_stall;
        n_o_kind = r_o_kind; n_o_trade = r_o_trade; n_o_buyer = r_o_buyer;
        n_o_seller = r_o_seller; n_o_qty = r_o_qty; n_o_price = r_o_price;
        n_o_left = r_o_left; n_o_last = r_o_last;
        lv_we = 1'b0; lv_wa = {opp, r_lvl}; lv_wd = '0; lv_ra = {opp, r_lvl};
        sl_we = 1'b0; sl_wa = {opp, r_lvl, r_head}; sl_wd = '0;
        sl_ra = {opp, r_lvl, lv_head};
        case (r_state)
            S_CLEAR: begin
                lv_we = 1'b1;
                lv_wa = r_clr;
                n_clr = r_clr + 1'b1;
            end
            S_IDLE: begin
                if (accept) begin
                    n_buy     = i_is_buy;
                    n_mkt     = i_is_market;
                    n_left    = i_order_qty;
                    n_price   = i_price_tick;
                    n_oid     = r_next_id;
                    n_next_id = r_next_id + 1'b1;
                    n_n       = '0;
                    if (i_order_qty == '0) begin
                        n_kind = K_DONE;
                    end else begin
                        n_kind = K_REJECT;
                    end
                    if (!i_is_market) n_lvl = LVL_W'(i_price_tick);
                    else if (i_is_buy) n_lvl = '0;
                    else n_lvl = LVL_TOP;
                end
            end
            S_LCHK: begin
                n_head = lv_head;
                n_cnt  = lv_cnt;
                if (lv_cnt == '0) begin
                    if (r_mkt) begin
                        if (lvl_end) n_kind = K_DISCARD;
                        else if (r_buy) n_lvl = r_lvl + 1'b1;
                        else n_lvl = r_lvl - 1'b1;
                    end
                end else begin
                    n_kind = K_REJECT;
                end
            end
            S_SCHK: begin
                n_q   = min_q;
                n_rq  = sl_qty;
                n_rid = sl_id;
            end
            S_FILL: begin
                if (can_out) begin
                    n_ovalid   = 1'b1;
                    n_o_kind   = K_FILL;
                    n_o_trade  = r_trade + 1'b1;
                    n_o_buyer  = r_buy ? r_oid : r_rid;
                    n_o_seller = r_buy ? r_rid : r_oid;
                    n_o_qty    = r_q;
                    n_o_price  = PRICE_W'(r_lvl);
                    n_o_left   = left_after;
                    n_o_last   = 1'b0;
                    n_trade    = r_trade + 1'b1;
                    n_left     = left_after;
                    n_n        = r_n + 1'b1;
                    n_kind     = K_DONE;
                    if (r_rq == r_q) begin
                        lv_we = 1'b1;
                        lv_wd = {next_head, r_cnt - 1'b1};
                    end else begin
                        sl_we = 1'b1;
                        sl_wd = {r_rq - r_q, r_rid};
                    end
                end
            end
            S_RRD: lv_ra = {!r_buy, r_lvl};
            S_RCHK: begin
                if (lv_cnt >= CNT_FULL) begin
                    n_kind = K_REJECT;
                end else begin
                    n_kind = K_RESTED;
                    lv_we  = 1'b1;
                    lv_wa  = {!r_buy, r_lvl};
                    lv_wd  = {lv_head, lv_cnt + 1'b1};
                    sl_we  = 1'b1;
                    sl_wa  = {!r_buy, r_lvl, tail};
                    sl_wd  = {r_left, r_oid};
                end
            end
            S_STAT: begin
                if (can_out) begin
                    n_ovalid   = 1'b1;
                    n_o_kind   = r_kind;
                    n_o_trade  = '0;
                    n_o_buyer  = r_buy ? r_oid : '0;
                    n_o_seller = r_buy ? '0 : r_oid;
                    n_o_qty    = '0;
                    n_o_price  = r_mkt ? '0 : r_price;
                    n_o_left   = r_left;
                    n_o_last   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_next_id <= '0;
            r_trade   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_next_id <= n_next_id;
            r_trade   <= n_trade;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buy <= n_buy; r_mkt <= n_mkt; r_left <= n_left; r_q <= n_q; r_rq <= n_rq;
        r_price <= n_price; r_oid <= n_oid; r_rid <= n_rid; r_lvl <= n_lvl;
        r_n <= n_n; r_kind <= n_kind; r_head <= n_head; r_cnt <= n_cnt;
        r_o_kind <= n_o_kind; r_o_trade <= n_o_trade; r_o_buyer <= n_o_buyer;
        r_o_seller <= n_o_seller; r_o_qty <= n_o_qty; r_o_price <= n_o_price;
        r_o_left <= n_o_left; r_o_last <= n_o_last;
    end

    assign o_valid        = r_ovalid;
    assign o_item_kind    = r_o_kind;
    assign o_trade_number = r_o_trade;
    assign o_buyer_id     = r_o_buyer;
    assign o_seller_id    = r_o_seller;
    assign o_fill_qty     = r_o_qty;
    assign o_fill_price   = r_o_price;
    assign o_left_qty     = r_o_left;
    assign o_last_item    = r_o_last;

endmodule
